FILE: hdl/wevr_pkg.sv
// ----------------------------------------------------------------------------
// wevr_pkg
// shared types and constants for the windowed event vote reporter
// ----------------------------------------------------------------------------
package wevr_pkg;

    // fixed field widths
    localparam int TAG_W       = 32;
    localparam int WIN_W       = 16;
    localparam int THRESH_W    = 17;
    localparam int FRAC_BITS   = 16;
    localparam int CFG_DATA_W  = 17;
    localparam int CFG_INDEX_W = 3;
    localparam int S_DATA_W    = 32;
    localparam int S_USER_W    = 1;
    localparam int M_DATA_W    = 32;
    localparam int M_USER_W    = 3;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WINDOW_FRAMES  = 3'd0,
        CFG_THRESHOLD_Q16  = 3'd1,
        CFG_HOLD_WINDOWS   = 3'd2,
        CFG_REPEAT_LIMIT   = 3'd3,
        CFG_START_EN       = 3'd4,
        CFG_CONTINUE_EN    = 3'd5,
        CFG_END_EN         = 3'd6
    } cfg_index_t;

    // change classification
    typedef enum logic [1:0] {
        CHANGE_NONE     = 2'd0,
        CHANGE_START    = 2'd1,
        CHANGE_CONTINUE = 2'd2,
        CHANGE_END      = 2'd3
    } change_kind_t;

    // report kind
    localparam logic KIND_BASE   = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // reset values of the configuration registers
    localparam logic [WIN_W-1:0]    WINDOW_FRAMES_RST = 16'd25;
    localparam logic [THRESH_W-1:0] THRESHOLD_RST     = 17'd32768;
    localparam logic [WIN_W-1:0]    HOLD_WINDOWS_RST  = 16'd1;
    localparam logic [WIN_W-1:0]    REPEAT_LIMIT_RST  = 16'd1;

endpackage

FILE: hdl/windowed_event_vote_reporter.sv
// ----------------------------------------------------------------------------
// windowed_event_vote_reporter
// counts flagged frames per window, votes on the active fraction and reports
// start, continue and end of event episodes with the matching frame tag
// ----------------------------------------------------------------------------
// an accepted input beat passes the input register, then the result register, to m_tvalid
// throughput: one beat per cycle unless m_tready holds a full result register;
//   the window counters, the vote multiply (threshold times frame count) and
//   the classification are combinational between the input and result registers
// reset: rst_n is asynchronous; it clears counters, episode status and saved
//   tags, empties both stages and returns all config registers to defaults
module windowed_event_vote_reporter #(
    parameter int COUNT_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // config write port
    input  logic                              cfg_we,
    input  logic [wevr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [wevr_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [31:0] frame_tag
    input  logic [wevr_pkg::S_DATA_W-1:0]     s_tdata,
    // [0] event_flag
    input  logic [wevr_pkg::S_USER_W-1:0]     s_tuser,
    // output stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [31:0] reported_tag
    output logic [wevr_pkg::M_DATA_W-1:0]     m_tdata,
    // [0] report_kind, [2:1] change_kind
    output logic [wevr_pkg::M_USER_W-1:0]     m_tuser
);
    import wevr_pkg::*;

    // compare width wide enough for both the counters and the 16 bit config
    localparam int CW = (COUNT_BITS > WIN_W) ? COUNT_BITS : WIN_W;
    // product width of threshold times frame count
    localparam int PW = COUNT_BITS + THRESH_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // ---------------- config registers ----------------
    logic [WIN_W-1:0]    window_frames_reg;
    logic [THRESH_W-1:0] threshold_reg;
    logic [WIN_W-1:0]    hold_windows_reg;
    logic [WIN_W-1:0]    repeat_limit_reg;
    logic                start_en_reg;
    logic                continue_en_reg;
    logic                end_en_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_frames_reg <= WINDOW_FRAMES_RST;
            threshold_reg     <= THRESHOLD_RST;
            hold_windows_reg  <= HOLD_WINDOWS_RST;
            repeat_limit_reg  <= REPEAT_LIMIT_RST;
            start_en_reg      <= 1'b1;
            continue_en_reg   <= 1'b0;
            end_en_reg        <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_WINDOW_FRAMES: window_frames_reg <= cfg_data[WIN_W-1:0];
                CFG_THRESHOLD_Q16: threshold_reg     <= cfg_data[THRESH_W-1:0];
                CFG_HOLD_WINDOWS:  hold_windows_reg  <= cfg_data[WIN_W-1:0];
                CFG_REPEAT_LIMIT:  repeat_limit_reg  <= cfg_data[WIN_W-1:0];
                CFG_START_EN:      start_en_reg      <= cfg_data[0];
                CFG_CONTINUE_EN:   continue_en_reg   <= cfg_data[0];
                CFG_END_EN:        end_en_reg        <= cfg_data[0];
                default:           ;  // index with no register, ignored
            endcase
        end
    end

    // ---------------- flow control ----------------
    // the result register moves when it is empty or taken downstream; the input register
    // also loads while empty, and stalls only when the result register is full and not taken
    logic s1_v_reg;
    logic out_v_reg;
    logic advance;
    logic fire;

    assign advance  = !out_v_reg || m_tready;
    assign s_tready = !s1_v_reg || advance;
    assign fire     = s1_v_reg && advance;

    // ---------------- input register ----------------
    logic             s1_flag_reg;
    logic [TAG_W-1:0] s1_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_v_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            s1_flag_reg <= s_tuser[0];
            s1_tag_reg  <= s_tdata[TAG_W-1:0];
        end
    end

    // ---------------- window state ----------------
    logic [COUNT_BITS-1:0] frames_reg,  frames_next;
    logic [COUNT_BITS-1:0] ones_reg,    ones_next;
    logic                  active_reg,  active_next;
    logic [COUNT_BITS-1:0] hold_reg,    hold_next;
    logic [COUNT_BITS-1:0] repeats_reg, repeats_next;
    logic [TAG_W-1:0]      one_tag_reg, one_tag_next;
    logic [TAG_W-1:0]      zero_tag_reg, zero_tag_next;

    // counts including the current frame
    logic [COUNT_BITS-1:0] frames_inc;
    logic [COUNT_BITS-1:0] ones_inc;
    logic [COUNT_BITS-1:0] hold_inc;
    logic [CW-1:0]         repeat_ext;
    logic                  win_close;
    logic [PW-1:0]         vote_lhs;
    logic [PW-1:0]         vote_rhs;
    logic                  vote;
    logic                  hold_done;
    change_kind_t          change;

    assign frames_inc = (frames_reg == COUNT_MAX) ? frames_reg : frames_reg + 1'b1;
    assign ones_inc   = !s1_flag_reg ? ones_reg :
                        (ones_reg == COUNT_MAX) ? ones_reg : ones_reg + 1'b1;
    assign hold_inc   = (hold_reg == COUNT_MAX) ? hold_reg : hold_reg + 1'b1;
    assign repeat_ext = CW'(repeat_limit_reg);

    // window of zero length closes on every frame, as a window of one
    assign win_close = (CW'(frames_inc) >= CW'(window_frames_reg))
                    || (frames_inc == COUNT_MAX);

    // active when ones * 2^16 >= threshold * frames
    assign vote_lhs  = PW'({ones_inc, {FRAC_BITS{1'b0}}});
    assign vote_rhs  = PW'(threshold_reg) * PW'(frames_inc);
    assign vote      = (vote_lhs >= vote_rhs);
    assign hold_done = (CW'(hold_inc) >= CW'(hold_windows_reg));

    always_comb
    begin
        frames_next   = frames_inc;
        ones_next     = ones_inc;
        active_next   = active_reg;
        hold_next     = hold_reg;
        repeats_next  = repeats_reg;
        one_tag_next  = s1_flag_reg ? s1_tag_reg : one_tag_reg;
        zero_tag_next = s1_flag_reg ? zero_tag_reg : s1_tag_reg;
        change        = CHANGE_NONE;
        if (win_close)
        begin
            frames_next = '0;
            ones_next   = '0;
            active_next = vote;
            if (!active_reg && vote)
            begin
                // new episode: arm the repeat budget
                change       = CHANGE_START;
                repeats_next = repeat_ext[COUNT_BITS-1:0];
                hold_next    = '0;
            end
            else if (active_reg && vote)
            begin
                hold_next = hold_inc;
                if (hold_done && (repeats_reg != '0))
                begin
                    change       = CHANGE_CONTINUE;
                    repeats_next = repeats_reg - 1'b1;
                    hold_next    = '0;
                end
            end
            else if (active_reg && !vote)
            begin
                change = CHANGE_END;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg   <= '0;
            ones_reg     <= '0;
            active_reg   <= 1'b0;
            hold_reg     <= '0;
            repeats_reg  <= '0;
            one_tag_reg  <= '0;
            zero_tag_reg <= '0;
        end
        else if (fire)
        begin
            frames_reg   <= frames_next;
            ones_reg     <= ones_next;
            active_reg   <= active_next;
            hold_reg     <= hold_next;
            repeats_reg  <= repeats_next;
            one_tag_reg  <= one_tag_next;
            zero_tag_reg <= zero_tag_next;
        end
    end

    // ---------------- result selection ----------------
    // a change whose report is disabled passes the frame on as a base frame
    logic [TAG_W-1:0] res_tag;
    logic             res_kind;
    change_kind_t     res_change;

    always_comb
    begin
        res_tag    = s1_tag_reg;
        res_kind   = KIND_BASE;
        res_change = CHANGE_NONE;
        case (change)
            CHANGE_START:
            begin
                if (start_en_reg)
                begin
                    res_tag    = one_tag_next;
                    res_kind   = KIND_REPORT;
                    res_change = CHANGE_START;
                end
            end
            CHANGE_CONTINUE:
            begin
                if (continue_en_reg)
                begin
                    res_tag    = one_tag_next;
                    res_kind   = KIND_REPORT;
                    res_change = CHANGE_CONTINUE;
                end
            end
            CHANGE_END:
            begin
                if (end_en_reg)
                begin
                    res_tag    = zero_tag_next;
                    res_kind   = KIND_REPORT;
                    res_change = CHANGE_END;
                end
            end
            default: ;
        endcase
    end

    // ---------------- result register ----------------
    logic [TAG_W-1:0] out_tag_reg;
    logic             out_kind_reg;
    change_kind_t     out_change_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_tag_reg    <= res_tag;
            out_kind_reg   <= res_kind;
            out_change_reg <= res_change;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_tag_reg;
    assign m_tuser  = {out_change_reg, out_kind_reg};

`ifndef SYNTHESIS
    // a held start or continue beat always belongs to an active episode
    a_report_active: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && ((out_change_reg == CHANGE_START) || (out_change_reg == CHANGE_CONTINUE)))
        |-> active_reg)
        else $error("start or continue reported while episode inactive");

    // a held end beat always follows the episode going inactive
    a_end_inactive: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && (out_change_reg == CHANGE_END)) |-> !active_reg)
        else $error("end reported while episode still active");

    // base beats never carry a change code
    a_base_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && (out_kind_reg == KIND_BASE)) |-> (out_change_reg == CHANGE_NONE))
        else $error("base beat with a change code");

    // the repeat budget only reloads on a start or steps down by one
    a_repeats_step: assert property (@(posedge clk) disable iff (!rst_n)
        (repeats_reg != $past(repeats_reg))
        |-> ($past(fire && win_close && !active_reg && vote)
             || ($past(repeats_reg) == repeats_reg + 1'b1)))
        else $error("repeat budget changed outside start or continue");
`endif

endmodule
